[hw/rtl/mwm_pkg.sv]
// Shared constants, operation codes and the noise generator step for the wavetable mixer.
package mwm_pkg;

    localparam int NUM_CHANNELS_DEF  = 4;
    localparam int TABLE_SAMPLES_DEF = 128;
    localparam int VOLUME_LEVELS_DEF = 16;
    localparam int NUM_WAVES_DEF     = 6;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_NOTE   = 3'd1;
    localparam logic [2:0] OP_VOLUME = 3'd2;
    localparam logic [2:0] OP_WAVE   = 3'd3;
    localparam logic [2:0] OP_TABLE  = 3'd4;

    localparam logic [2:0]  NOISE_KIND   = 3'd5;
    localparam logic [15:0] LFSR_SEED    = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS    = 16'hB400;
    localparam int          VOLUME_RESET = 7;
    localparam int          LEVEL_MAX    = 1023;
    localparam int          LEVEL_W      = 10;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic [15:0] r;
        r = {1'b0, s[15:1]};
        if (s[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

[hw/rtl/mwm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/multichannel_wavetable_mixer_unit.sv]
// Top level of the multichannel wavetable oscillator and mixer.
// A tick word walks each channel in turn through the noise, phase, address, read and accumulate
// states, on the one shared multiplier and the table read port; ready returns with the level
// word, or later while the previous level word still waits. Note, volume and wave words are
// taken in the idle state; a table write passes through the address and write states.
// Synchronous active-low reset restores phases, steps, volumes, kinds and the noise seed.
module multichannel_wavetable_mixer_unit #(
    parameter int NUM_CHANNELS  = mwm_pkg::NUM_CHANNELS_DEF,
    parameter int TABLE_SAMPLES = mwm_pkg::TABLE_SAMPLES_DEF,
    parameter int VOLUME_LEVELS = mwm_pkg::VOLUME_LEVELS_DEF,
    parameter int NUM_WAVES     = mwm_pkg::NUM_WAVES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // channel[1:0], wave_select[4:2], volume_select[8:5], table_index[15:9], value[31:16]
    input  logic [31:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // level[9:0], zero fill above
    output logic [15:0] m_tdata
);

    localparam int DEPTH   = NUM_WAVES * VOLUME_LEVELS * TABLE_SAMPLES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int KIND_W  = (NUM_WAVES > 1) ? $clog2(NUM_WAVES) : 1;
    localparam int VOL_W   = $clog2((VOLUME_LEVELS > 8) ? VOLUME_LEVELS : 8);
    localparam int ROW_W   = $clog2(NUM_WAVES * VOLUME_LEVELS);
    localparam int POS_W   = $clog2(TABLE_SAMPLES);
    localparam int A_W     = ROW_W + 16;
    localparam int PROD_W  = A_W + 16;
    localparam int SUM_W   = $clog2(NUM_CHANNELS * 255 + 1);
    localparam int LEVEL_W_LOC = mwm_pkg::LEVEL_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_NOISE = 4'd1;
    localparam logic [3:0] ST_PHASE = 4'd2;
    localparam logic [3:0] ST_ADDR  = 4'd3;
    localparam logic [3:0] ST_READ  = 4'd4;
    localparam logic [3:0] ST_ACC   = 4'd5;
    localparam logic [3:0] ST_OUT   = 4'd6;
    localparam logic [3:0] ST_WADDR = 4'd7;
    localparam logic [3:0] ST_WRITE = 4'd8;

    logic [2:0]  in_op;
    logic [1:0]  in_ch;
    logic [2:0]  in_ws;
    logic [3:0]  in_vs;
    logic [6:0]  in_ti;
    logic [15:0] in_val;
    logic        accept;

    assign in_op  = s_tuser;
    assign in_ch  = s_tdata[1:0];
    assign in_ws  = s_tdata[4:2];
    assign in_vs  = s_tdata[8:5];
    assign in_ti  = s_tdata[15:9];
    assign in_val = s_tdata[31:16];

    logic [3:0]        state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [15:0]       phase_reg [NUM_CHANNELS];
    logic [15:0]       phase_next [NUM_CHANNELS];
    logic [15:0]       step_reg [NUM_CHANNELS];
    logic [15:0]       step_next [NUM_CHANNELS];
    logic [VOL_W-1:0]  vol_reg [NUM_CHANNELS];
    logic [VOL_W-1:0]  vol_next [NUM_CHANNELS];
    logic [KIND_W-1:0] kind_reg [NUM_CHANNELS];
    logic [KIND_W-1:0] kind_next [NUM_CHANNELS];
    logic [15:0]       lfsr_reg, lfsr_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              active_reg, active_next;
    logic [POS_W-1:0]  ti_reg, ti_next;
    logic [7:0]        wdata_reg, wdata_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              m_valid_reg, m_valid_next;
    logic [LEVEL_W_LOC-1:0] level_reg, level_next;

    logic [A_W-1:0]    mul_a;
    logic [15:0]       mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [15:0]       lfsr_step;
    logic              is_noise;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(16 - LEVEL_W_LOC){1'b0}}, level_reg};
    assign lfsr_step = mwm_pkg::lfsr_next(lfsr_reg);
    assign is_noise  = (3'(kind_reg[ch_reg]) == mwm_pkg::NOISE_KIND);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_NOISE: begin
                mul_a = is_noise ? A_W'(lfsr_step) : A_W'(32'h0001_0000);
                mul_b = step_reg[ch_reg];
            end
            ST_ADDR: begin
                mul_a = {row_reg, phase_reg[ch_reg]};
                mul_b = 16'(TABLE_SAMPLES);
            end
            ST_WADDR: begin
                mul_a = A_W'(row_reg);
                mul_b = 16'(TABLE_SAMPLES);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign ram_we    = (state_reg == ST_WRITE);
    assign ram_waddr = prod_reg[ADDR_W-1:0] + ADDR_W'(ti_reg);
    assign ram_re    = (state_reg == ST_READ);
    assign ram_raddr = prod_reg[16 +: ADDR_W];

    always_comb begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        phase_next   = phase_reg;
        step_next    = step_reg;
        vol_next     = vol_reg;
        kind_next    = kind_reg;
        lfsr_next    = lfsr_reg;
        prod_next    = prod_reg;
        row_next     = row_reg;
        active_next  = active_reg;
        ti_next      = ti_reg;
        wdata_next   = wdata_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg;
        level_next   = level_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        mwm_pkg::OP_TICK: begin
                            ch_next    = '0;
                            sum_next   = '0;
                            state_next = ST_NOISE;
                        end
                        mwm_pkg::OP_NOTE: begin
                            if (32'(in_ch) < NUM_CHANNELS) begin
                                step_next[CH_W'(in_ch)] = in_val;
                            end
                        end
                        mwm_pkg::OP_VOLUME: begin
                            if (32'(in_ch) < NUM_CHANNELS &&
                                32'(in_val) < VOLUME_LEVELS) begin
                                vol_next[CH_W'(in_ch)] = VOL_W'(in_val);
                            end
                        end
                        mwm_pkg::OP_WAVE: begin
                            if (32'(in_ch) < NUM_CHANNELS && 32'(in_val) < NUM_WAVES) begin
                                kind_next[CH_W'(in_ch)] = KIND_W'(in_val);
                            end
                        end
                        mwm_pkg::OP_TABLE: begin
                            if (32'(in_ws) < NUM_WAVES && 32'(in_vs) < VOLUME_LEVELS &&
                                32'(in_ti) < TABLE_SAMPLES) begin
                                row_next   = ROW_W'(32'(in_ws) * VOLUME_LEVELS + 32'(in_vs));
                                ti_next    = POS_W'(in_ti);
                                wdata_next = in_val[7:0];
                                state_next = ST_WADDR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_NOISE: begin
                if (is_noise) begin
                    lfsr_next = lfsr_step;
                end
                prod_next   = mul_p;
                row_next    = ROW_W'(32'(kind_reg[ch_reg]) * VOLUME_LEVELS +
                                     32'(vol_reg[ch_reg]));
                active_next = (step_reg[ch_reg] != 16'd0) &&
                              (32'(vol_reg[ch_reg]) < VOLUME_LEVELS);
                state_next  = ST_PHASE;
            end
            ST_PHASE: begin
                phase_next[ch_reg] = phase_reg[ch_reg] + prod_reg[31:16];
                state_next         = ST_ADDR;
            end
            ST_ADDR: begin
                prod_next  = mul_p;
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (active_reg) begin
                    sum_next = sum_reg + SUM_W'(ram_rdata);
                end
                if (32'(ch_reg) == NUM_CHANNELS - 1) begin
                    state_next = ST_OUT;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_NOISE;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    level_next   = (32'(sum_reg) > mwm_pkg::LEVEL_MAX) ?
                                   LEVEL_W_LOC'(mwm_pkg::LEVEL_MAX) : LEVEL_W_LOC'(sum_reg);
                    state_next   = ST_IDLE;
                end
            end
            ST_WADDR: begin
                prod_next  = mul_p;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= '0;
            lfsr_reg    <= mwm_pkg::LFSR_SEED;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                phase_reg[c] <= '0;
                step_reg[c]  <= '0;
                vol_reg[c]   <= VOL_W'(mwm_pkg::VOLUME_RESET);
                kind_reg[c]  <= '0;
            end
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            lfsr_reg    <= lfsr_next;
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            vol_reg     <= vol_next;
            kind_reg    <= kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        row_reg    <= row_next;
        active_reg <= active_next;
        ti_reg     <= ti_next;
        wdata_reg  <= wdata_next;
        sum_reg    <= sum_next;
        level_reg  <= level_next;
    end

    mwm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wdata_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[verif/mix_level_checker.sv]
// Checker that predicts the mixer's level words from the accepted input words and compares them.
`timescale 1ns / 1ps

module mix_level_checker (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    input  logic                                          s_tready,
    input  logic [31:0]                                   s_tdata,
    input  logic [2:0]                                    s_tuser,
    input  logic                                          m_tvalid,
    input  logic                                          m_tready,
    input  logic [15:0]                                   m_tdata,
    output logic [mwm_pkg::NUM_CHANNELS_DEF-1:0][13:0]    tick_addr,
    output logic [mwm_pkg::NUM_CHANNELS_DEF-1:0]          tick_live,
    output int                                            pending,
    output int                                            fail_count
);

    localparam int NCH         = mwm_pkg::NUM_CHANNELS_DEF;
    localparam int SAMPLES     = mwm_pkg::TABLE_SAMPLES_DEF;
    localparam int VOLUMES     = mwm_pkg::VOLUME_LEVELS_DEF;
    localparam int WAVES       = mwm_pkg::NUM_WAVES_DEF;
    localparam int TABLE_DEPTH = WAVES * VOLUMES * SAMPLES;

    typedef struct packed {
        logic [NCH-1:0][15:0] ph;
        logic [15:0]          lfsr;
        logic [NCH-1:0][13:0] addr;
        logic [NCH-1:0]       live;
    } tick_plan_t;

    logic [15:0] phase_acc [NCH];
    logic [15:0] note_step [NCH];
    logic [3:0]  chan_vol  [NCH];
    logic [2:0]  chan_kind [NCH];
    logic [15:0] noise_reg;
    logic [7:0]  wave_mem  [TABLE_DEPTH];
    logic [9:0]  level_due [$];
    int          errs = 0;

    // Works out what a tick accepted now would do, without changing any state.
    function automatic tick_plan_t plan_tick();
        tick_plan_t  p;
        logic [15:0] l;
        logic [31:0] stp;
        logic [31:0] pos;
        l = noise_reg;
        for (int c = 0; c < NCH; c++) begin
            stp = {16'd0, note_step[c]};
            if (chan_kind[c] == mwm_pkg::NOISE_KIND) begin
                l = {1'b0, l[15:1]} ^ (l[0] ? mwm_pkg::LFSR_TAPS : 16'h0000);
                stp = ({16'd0, l} * stp) >> 16;
            end
            p.ph[c]   = phase_acc[c] + stp[15:0];
            pos       = ({16'd0, p.ph[c]} * SAMPLES) >> 16;
            p.addr[c] = 14'((chan_kind[c] * VOLUMES + chan_vol[c]) * SAMPLES + pos);
            p.live[c] = (note_step[c] != 16'd0);
        end
        p.lfsr = l;
        return p;
    endfunction

    always @(posedge aclk) begin
        tick_plan_t  p;
        logic [11:0] sum;
        logic [9:0]  want;
        logic [1:0]  ch;
        logic [2:0]  ws;
        logic [3:0]  vs;
        logic [6:0]  ti;
        logic [15:0] val;
        if (!aresetn) begin
            for (int c = 0; c < NCH; c++) begin
                phase_acc[c] = 16'd0;
                note_step[c] = 16'd0;
                chan_vol[c]  = 4'(mwm_pkg::VOLUME_RESET);
                chan_kind[c] = 3'd0;
            end
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                wave_mem[i] = 8'd0;
            end
            noise_reg = mwm_pkg::LFSR_SEED;
            level_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (level_due.size() == 0) begin
                    errs++;
                    if (errs <= 10) begin
                        $display("level word %0d arrived with none expected", m_tdata[9:0]);
                    end
                end else begin
                    want = level_due.pop_front();
                    if (m_tdata[9:0] !== want) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("level mismatch: expected %0d, got %0d", want,
                                     m_tdata[9:0]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                ch  = s_tdata[1:0];
                ws  = s_tdata[4:2];
                vs  = s_tdata[8:5];
                ti  = s_tdata[15:9];
                val = s_tdata[31:16];
                case (s_tuser)
                    mwm_pkg::OP_TICK: begin
                        p = plan_tick();
                        sum = 12'd0;
                        for (int c = 0; c < NCH; c++) begin
                            phase_acc[c] = p.ph[c];
                            if (p.live[c] && p.addr[c] < TABLE_DEPTH) begin
                                sum = sum + wave_mem[p.addr[c]];
                            end
                        end
                        noise_reg = p.lfsr;
                        if (sum > mwm_pkg::LEVEL_MAX) begin
                            sum = 12'(mwm_pkg::LEVEL_MAX);
                        end
                        level_due.push_back(sum[9:0]);
                    end
                    mwm_pkg::OP_NOTE: begin
                        if (ch < NCH) begin
                            note_step[ch] = val;
                        end
                    end
                    mwm_pkg::OP_VOLUME: begin
                        if (ch < NCH && val < VOLUMES) begin
                            chan_vol[ch] = val[3:0];
                        end
                    end
                    mwm_pkg::OP_WAVE: begin
                        if (ch < NCH && val < WAVES) begin
                            chan_kind[ch] = val[2:0];
                        end
                    end
                    mwm_pkg::OP_TABLE: begin
                        if (ws < WAVES && vs < VOLUMES && ti < SAMPLES) begin
                            wave_mem[(ws * VOLUMES + vs) * SAMPLES + ti] = val[7:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        p = plan_tick();
        tick_addr  <= p.addr;
        tick_live  <= p.live;
        pending    <= level_due.size();
        fail_count <= errs;
    end

endmodule

[verif/multichannel_wavetable_mixer_unit_tb.sv]
// Testbench top for the wavetable mixer: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module multichannel_wavetable_mixer_unit_tb;

    localparam int NCH          = mwm_pkg::NUM_CHANNELS_DEF;
    localparam int WAVES        = mwm_pkg::NUM_WAVES_DEF;
    localparam int TABLE_DEPTH  = mwm_pkg::NUM_WAVES_DEF * mwm_pkg::VOLUME_LEVELS_DEF *
                                  mwm_pkg::TABLE_SAMPLES_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 250;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;
    logic [2:0]  s_tuser  = 3'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    logic [NCH-1:0][13:0] tick_addr;
    logic [NCH-1:0]       tick_live;
    int                   pending;
    int                   fail_count;

    logic hold_req  = 1'b0;
    int   stall_pct = 0;
    int   idle_pct  = 0;
    bit   tbl_written [TABLE_DEPTH];

    multichannel_wavetable_mixer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mix_level_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .tick_addr  (tick_addr),
        .tick_live  (tick_live),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        bit hold_served;
        hold_served = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic logic [31:0] pack_word(input logic [1:0] ch, input logic [2:0] ws,
                                              input logic [3:0] vs, input logic [6:0] ti,
                                              input logic [15:0] val);
        return {val, ti, vs, ws, ch};
    endfunction

    task automatic push_word(input logic [2:0] op, input logic [31:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == mwm_pkg::OP_TABLE && data[4:2] < WAVES) begin
            tbl_written[{data[4:2], data[8:5], data[15:9]}] = 1'b1;
        end
    endtask

    // A tick must never sum a table entry that was never written, so the entries
    // its live channels are about to read are filled first.
    task automatic issue_tick();
        logic [13:0] a;
        logic [31:0] r;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        for (int c = 0; c < NCH; c++) begin
            a = tick_addr[c];
            if (tick_live[c] && !tbl_written[a]) begin
                r = $urandom;
                push_word(mwm_pkg::OP_TABLE,
                          pack_word(r[1:0], a[13:11], a[10:7], a[6:0], r[31:16]));
            end
        end
        push_word(mwm_pkg::OP_TICK, $urandom);
    endtask

    task automatic sender_idle();
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic random_word();
        int          r;
        logic [31:0] d;
        logic [2:0]  op;
        r = $urandom_range(0, 99);
        d = $urandom;
        if (r < 30) begin
            issue_tick();
        end else if (r < 50) begin
            case ($urandom_range(0, 3))
                0: d[31:16] = 16'd0;
                1: d[31:16] = 16'($urandom_range(1, 1023));
                2: d[31:16] = 16'($urandom_range(1024, 8191));
                default: d[31:16] = 16'($urandom);
            endcase
            push_word(mwm_pkg::OP_NOTE, d);
        end else if (r < 62) begin
            if ($urandom_range(0, 4) != 0) begin
                d[31:16] = 16'($urandom_range(0, 15));
            end
            push_word(mwm_pkg::OP_VOLUME, d);
        end else if (r < 74) begin
            if ($urandom_range(0, 4) != 0) begin
                d[31:16] = 16'($urandom_range(0, 5));
            end
            push_word(mwm_pkg::OP_WAVE, d);
        end else if (r < 94) begin
            push_word(mwm_pkg::OP_TABLE, d);
        end else begin
            op = OP_UNUSED_FIRST + 3'($urandom_range(0, 2));
            push_word(op, d);
        end
    endtask

    task automatic directed_words();
        issue_tick();
        push_word(mwm_pkg::OP_NOTE, pack_word(2'd0, 3'd0, 4'd0, 7'd0, 16'h0200));
        push_word(mwm_pkg::OP_NOTE, pack_word(2'd1, 3'd0, 4'd0, 7'd0, 16'hFFFF));
        push_word(mwm_pkg::OP_NOTE, pack_word(2'd2, 3'd0, 4'd0, 7'd0, 16'h0001));
        push_word(mwm_pkg::OP_NOTE, pack_word(2'd3, 3'd0, 4'd0, 7'd0, 16'h8000));
        push_word(mwm_pkg::OP_TABLE, pack_word(2'd0, 3'd0, 4'd7, 7'd1, 16'hFFFF));
        push_word(mwm_pkg::OP_TABLE, pack_word(2'd0, 3'd0, 4'd7, 7'd127, 16'hFFFF));
        push_word(mwm_pkg::OP_TABLE, pack_word(2'd0, 3'd0, 4'd7, 7'd0, 16'hFFFF));
        push_word(mwm_pkg::OP_TABLE, pack_word(2'd0, 3'd0, 4'd7, 7'd64, 16'hFFFF));
        issue_tick();
        push_word(mwm_pkg::OP_VOLUME, pack_word(2'd0, 3'd0, 4'd0, 7'd0, 16'd15));
        push_word(mwm_pkg::OP_VOLUME, pack_word(2'd1, 3'd0, 4'd0, 7'd0, 16'd0));
        push_word(mwm_pkg::OP_VOLUME, pack_word(2'd2, 3'd0, 4'd0, 7'd0, 16'd16));
        push_word(mwm_pkg::OP_VOLUME, pack_word(2'd3, 3'd0, 4'd0, 7'd0, 16'hFFFF));
        push_word(mwm_pkg::OP_WAVE,
                  pack_word(2'd2, 3'd0, 4'd0, 7'd0, 16'(mwm_pkg::NOISE_KIND)));
        push_word(mwm_pkg::OP_WAVE, pack_word(2'd3, 3'd0, 4'd0, 7'd0, 16'd6));
        push_word(mwm_pkg::OP_WAVE, pack_word(2'd1, 3'd0, 4'd0, 7'd0, 16'hFFFF));
        push_word(mwm_pkg::OP_WAVE, pack_word(2'd0, 3'd0, 4'd0, 7'd0, 16'd4));
        push_word(mwm_pkg::OP_TABLE, pack_word(2'd0, 3'd6, 4'd0, 7'd0, 16'h00AA));
        push_word(mwm_pkg::OP_TABLE, pack_word(2'd3, 3'd7, 4'd15, 7'd127, 16'hFFFF));
        push_word(mwm_pkg::OP_TABLE, pack_word(2'd0, 3'd5, 4'd15, 7'd127, 16'h0000));
        push_word(OP_UNUSED_FIRST, $urandom);
        push_word(OP_UNUSED_FIRST + 3'd1, $urandom);
        push_word(OP_UNUSED_FIRST + 3'd2, $urandom);
        issue_tick();
        push_word(mwm_pkg::OP_NOTE, pack_word(2'd3, 3'd0, 4'd0, 7'd0, 16'd0));
        issue_tick();
    endtask

    initial begin
        int wait_n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_words();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 52; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 52; end
                default: begin idle_pct = 28; stall_pct <= 28; end
            endcase
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (ph == 0 && i == 150) begin
                    hold_req <= 1'b1;
                end
                sender_idle();
                random_word();
            end
            if (ph == 1) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_n = 0;
        while (pending != 0 && wait_n < 20000) begin
            @(posedge aclk);
            wait_n++;
        end
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[multichannel_wavetable_mixer_unit.f]
hw/rtl/mwm_pkg.sv
hw/rtl/mwm_ram.sv
hw/rtl/multichannel_wavetable_mixer_unit.sv
verif/mix_level_checker.sv
verif/multichannel_wavetable_mixer_unit_tb.sv
